// ===== design/tkst_pkg.sv =====
// shared types, constants and the name clean-up function for the top-k score table
// no dependencies
package tkst_pkg;

  localparam int SCORE_W          = 32;
  localparam int NAME_W           = 64;
  localparam int INDEX_W          = 3;
  localparam int RANK_W           = 3;
  localparam int MAX_CHARS        = NAME_W / 8;
  localparam int ENTRIES_DEFAULT  = 8;
  localparam int NAME_CHARS_DEFAULT = 8;

  localparam logic [NAME_W-1:0] EMPTY_NAME = 64'h656D_7074_7900_0000;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic                      submit;
    logic                      insert;
    logic signed [SCORE_W-1:0] score;
    logic [NAME_W-1:0]         name;
  } cell_ctrl_t;

  // keep the top nchars bytes, and stop at the first zero byte
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw,
                                                    input int nchars);
    logic [NAME_W-1:0] out;
    logic              ended;
    logic [7:0]        ch;
    out   = '0;
    ended = 1'b0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      ch = raw[NAME_W-1-8*i -: 8];
      if (i >= nchars || ch == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        out[NAME_W-1-8*i -: 8] = ch;
      end
    end
    return out;
  endfunction

endpackage

// ===== design/tkst_cell.sv =====
// one table position: score, name and highlight flag
// takes its neighbour's entry when a new score passes it; uses tkst_pkg
module tkst_cell #(
  parameter logic [tkst_pkg::NAME_W-1:0] RESET_NAME = tkst_pkg::EMPTY_NAME
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tkst_pkg::cell_ctrl_t               ctl,
  input  logic                               prev_lt,
  input  logic signed [tkst_pkg::SCORE_W-1:0] prev_score,
  input  logic [tkst_pkg::NAME_W-1:0]        prev_name,
  output logic signed [tkst_pkg::SCORE_W-1:0] score,
  output logic [tkst_pkg::NAME_W-1:0]        name,
  output logic                               lt,
  output logic                               hl
);
  import tkst_pkg::*;

  assign lt = score < ctl.score;

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
      name  <= RESET_NAME;
      hl    <= 1'b0;
    end else begin
      if (ctl.insert && lt) begin
        if (prev_lt) begin
          score <= prev_score;
          name  <= prev_name;
        end else begin
          score <= ctl.score;
          name  <= ctl.name;
        end
      end
      // a rejected submit clears every flag
      if (ctl.submit) begin
        hl <= ctl.insert & lt & ~prev_lt;
      end
    end
  end

endmodule

// ===== design/top_k_score_table_insert.sv =====
// A command is taken when start is high and busy is low; its single result
// appears two cycles later for one cycle with done high, and must be taken then,
// since the block cannot be held off. Every command, submit or read, takes two
// cycles: one to register the command, one in which the row of cells compares
// the offered score against every stored score at once and shifts the lower
// entries down by one place. A new command can be taken in the cycle done is high.
// On a submit, entry_score, entry_name and highlighted are 0; on a read,
// inserted and rank are 0. Reads at or beyond ENTRIES return zeros.
//
// top level: command register, row of tkst_cell, result registers; uses tkst_pkg
module top_k_score_table_insert #(
  parameter int ENTRIES    = tkst_pkg::ENTRIES_DEFAULT,
  parameter int NAME_CHARS = tkst_pkg::NAME_CHARS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic signed [tkst_pkg::SCORE_W-1:0] score,
  input  logic [tkst_pkg::NAME_W-1:0]         name,
  input  logic [tkst_pkg::INDEX_W-1:0]        entry_index,
  output logic                                done,
  output logic                                inserted,
  output logic [tkst_pkg::RANK_W-1:0]         rank,
  output logic signed [tkst_pkg::SCORE_W-1:0] entry_score,
  output logic [tkst_pkg::NAME_W-1:0]         entry_name,
  output logic                                highlighted
);
  import tkst_pkg::*;

  localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [NAME_W-1:0] RESET_NAME = clean_name(EMPTY_NAME, NAME_CHARS);

  // registered command
  op_t                   cmd_op;
  logic signed [SCORE_W-1:0] cmd_score;
  logic [NAME_W-1:0]     cmd_name;
  logic [INDEX_W-1:0]    cmd_index;

  cell_ctrl_t            ctl;

  logic signed [SCORE_W-1:0] cell_score [ENTRIES];
  logic [NAME_W-1:0]     cell_name  [ENTRIES];
  logic                  cell_lt    [ENTRIES];
  logic                  cell_hl    [ENTRIES];

  logic                  accept;
  logic [POS_W-1:0]      ins_pos;
  logic signed [SCORE_W-1:0] rd_score;
  logic [NAME_W-1:0]     rd_name;
  logic                  rd_hl;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op    <= op_t'(operation);
      cmd_score <= score;
      cmd_name  <= clean_name(name, NAME_CHARS);
      cmd_index <= entry_index;
    end
  end

  always_comb begin
    ctl.submit = busy && (cmd_op == OP_SUBMIT);
    ctl.insert = ctl.submit && cell_lt[ENTRIES-1];
    ctl.score  = cmd_score;
    ctl.name   = cmd_name;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      tkst_cell #(.RESET_NAME(RESET_NAME)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_lt    (1'b0),
        .prev_score (cmd_score),
        .prev_name  (cmd_name),
        .score      (cell_score[i]),
        .name       (cell_name[i]),
        .lt         (cell_lt[i]),
        .hl         (cell_hl[i])
      );
    end else begin : g_body
      tkst_cell #(.RESET_NAME(RESET_NAME)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_lt    (cell_lt[i-1]),
        .prev_score (cell_score[i-1]),
        .prev_name  (cell_name[i-1]),
        .score      (cell_score[i]),
        .name       (cell_name[i]),
        .lt         (cell_lt[i]),
        .hl         (cell_hl[i])
      );
    end
  end

  // the insert point is the first cell holding a lower score
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_lt[i] && (i == 0 || !cell_lt[(i > 0) ? i-1 : 0])) begin
        ins_pos = ins_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    rd_score = '0;
    rd_name  = '0;
    rd_hl    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (32'(cmd_index) == i) begin
        rd_score = cell_score[i];
        rd_name  = cell_name[i];
        rd_hl    = cell_hl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accept;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (cmd_op == OP_SUBMIT) begin
        inserted    <= ctl.insert;
        rank        <= ctl.insert ? RANK_W'(ins_pos) : '0;
        entry_score <= '0;
        entry_name  <= '0;
        highlighted <= 1'b0;
      end else begin
        inserted    <= 1'b0;
        rank        <= '0;
        entry_score <= rd_score;
        entry_name  <= rd_name;
        highlighted <= rd_hl;
      end
    end
  end

endmodule

// ===== tb/score_table_checker.sv =====
`timescale 1ns / 1ps
// checker for the top-k score table: watches the command and result ports,
// keeps its own sorted table and compares every result; uses tkst_pkg
module score_table_checker
  import tkst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      operation,
  input  logic signed [SCORE_W-1:0] score,
  input  logic [NAME_W-1:0]         name,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic                      done,
  input  logic                      inserted,
  input  logic [RANK_W-1:0]         rank,
  input  logic signed [SCORE_W-1:0] entry_score,
  input  logic [NAME_W-1:0]         entry_name,
  input  logic                      highlighted,
  output int                        fail_count,
  output int                        pending,
  output int                        placed
);

  localparam int ROWS  = ENTRIES_DEFAULT;
  localparam int CHARS = NAME_CHARS_DEFAULT;

  typedef struct {
    logic                      inserted;
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] entry_score;
    logic [NAME_W-1:0]         entry_name;
    logic                      highlighted;
  } outcome_t;

  logic signed [SCORE_W-1:0] board_score [ROWS];
  logic [NAME_W-1:0]         board_name [ROWS];
  int                        hl_row;
  logic                      hl_on;
  outcome_t                  due_results[$];

  // name stops at the first zero byte or after CHARS characters
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    kept = '0;
    for (int i = 0; i < CHARS; i++) begin
      if (raw[NAME_W-1-8*i -: 8] == 8'h00) break;
      kept[NAME_W-1-8*i -: 8] = raw[NAME_W-1-8*i -: 8];
    end
    return kept;
  endfunction

  task automatic clear_board();
    for (int i = 0; i < ROWS; i++) begin
      board_score[i] = '0;
      board_name[i]  = trim_name(EMPTY_NAME);
    end
    hl_row = 15;
    hl_on  = 1'b0;
  endtask

  function automatic outcome_t board_update(input logic op, input logic signed [SCORE_W-1:0] sc,
                                            input logic [NAME_W-1:0] nm,
                                            input logic [INDEX_W-1:0] idx);
    outcome_t r;
    int       row;
    r = '{1'b0, '0, '0, '0, 1'b0};
    if (op == OP_SUBMIT) begin
      if (sc > board_score[ROWS-1]) begin
        row = ROWS - 1;
        // equal older scores keep their place above the newcomer
        while (row > 0 && board_score[row-1] < sc) begin
          board_score[row] = board_score[row-1];
          board_name[row]  = board_name[row-1];
          row--;
        end
        board_score[row] = sc;
        board_name[row]  = trim_name(nm);
        hl_row = row;
        hl_on  = 1'b1;
        r.inserted = 1'b1;
        r.rank     = row[RANK_W-1:0];
      end else begin
        hl_row = 15;
        hl_on  = 1'b0;
      end
    end else if (int'(idx) < ROWS) begin
      r.entry_score = board_score[idx];
      r.entry_name  = board_name[idx];
      r.highlighted = hl_on && hl_row == int'(idx);
    end
    return r;
  endfunction

  task automatic check_field(input string label, input logic [NAME_W-1:0] want,
                             input logic [NAME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    placed     = 0;
    clear_board();
  end

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      clear_board();
      due_results.delete();
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          fail_count++;
        end else begin
          w = due_results.pop_front();
          check_field("inserted", w.inserted, inserted);
          check_field("rank", w.rank, rank);
          check_field("entry_score", w.entry_score, entry_score);
          check_field("entry_name", w.entry_name, entry_name);
          check_field("highlighted", w.highlighted, highlighted);
        end
      end
      if (start && !busy) begin
        w = board_update(operation, score, name, entry_index);
        if (w.inserted) placed++;
        due_results.push_back(w);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// stimulus, watchdog and verdict for the top-k score table
// depends on tkst_pkg, top_k_score_table_insert and score_table_checker
module tb_top;
  import tkst_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 700;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      operation;
  logic signed [SCORE_W-1:0] score;
  logic [NAME_W-1:0]         name;
  logic [INDEX_W-1:0]        entry_index;
  logic                      done;
  logic                      inserted;
  logic [RANK_W-1:0]         rank;
  logic signed [SCORE_W-1:0] entry_score;
  logic [NAME_W-1:0]         entry_name;
  logic                      highlighted;

  int fail_count;
  int pending;
  int placed;
  int submits;
  int reads;
  int quiet_cycles;
  int drift;
  bit idling_on;

  top_k_score_table_insert DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .score(score), .name(name), .entry_index(entry_index), .done(done),
    .inserted(inserted), .rank(rank), .entry_score(entry_score),
    .entry_name(entry_name), .highlighted(highlighted)
  );

  score_table_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .score(score), .name(name), .entry_index(entry_index), .done(done),
    .inserted(inserted), .rank(rank), .entry_score(entry_score),
    .entry_name(entry_name), .highlighted(highlighted),
    .fail_count(fail_count), .pending(pending), .placed(placed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // nothing taken and nothing returned for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input op_t op, input logic signed [SCORE_W-1:0] sc,
                           input logic [NAME_W-1:0] nm, input logic [INDEX_W-1:0] idx);
    @(negedge clk);
    start       <= 1'b1;
    operation   <= op;
    score       <= sc;
    name        <= nm;
    entry_index <= idx;
    do @(posedge clk); while (busy);
    if (op == OP_SUBMIT) submits++;
    else reads++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      operation   <= 1'($urandom_range(1));
      score       <= $urandom;
      name        <= {$urandom, $urandom};
      entry_index <= INDEX_W'($urandom_range(7));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] nm;
    nm = {$urandom, $urandom};
    // a zero byte somewhere ends the name early
    if ($urandom_range(99) < 30) nm[8*$urandom_range(7) +: 8] = 8'h00;
    return nm;
  endfunction

  initial begin
    logic signed [SCORE_W-1:0] sc;
    int pick;
    start       = 1'b0;
    operation   = OP_SUBMIT;
    score       = '0;
    name        = '0;
    entry_index = '0;
    submits     = 0;
    reads       = 0;
    quiet_cycles = 0;
    drift       = 1;
    rst         = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fresh table, ties with zero, extremes, truncated names
    send_item(OP_READ, '0, '0, 3'd0);
    send_item(OP_READ, '0, '0, 3'd7);
    send_item(OP_SUBMIT, 32'sd0, 64'h4142_4344_4546_4748, 3'd5);
    send_item(OP_SUBMIT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
    send_item(OP_SUBMIT, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);
    send_item(OP_READ, '0, '0, 3'd0);
    send_item(OP_SUBMIT, 32'sd5, 64'h4142_0043_4445_4647, 3'd2);
    send_item(OP_READ, '0, '0, 3'd1);
    send_item(OP_SUBMIT, 32'sd5, 64'h5859_5A00_0000_0000, 3'd1);
    send_item(OP_READ, '0, '0, 3'd2);
    send_item(OP_READ, '0, '0, 3'd1);
    send_item(OP_SUBMIT, -32'sd5, 64'h0, 3'd3);
    send_item(OP_READ, '0, '0, 3'd2);
    send_item(OP_SUBMIT, 32'sd100, 64'h0, 3'd6);
    send_item(OP_SUBMIT, 32'sd1, 64'h00FF_FFFF_FFFF_FFFF, 3'd4);
    send_item(OP_SUBMIT, 32'sd1, 64'h7A00_0000_0000_0000, 3'd4);
    send_item(OP_READ, '0, '0, 3'd5);
    send_item(OP_READ, '0, '0, 3'd7);
    send_item(OP_SUBMIT, -32'sd1, 64'h2020_2020_2020_2020, 3'd0);
    send_item(OP_READ, '0, '0, 3'd4);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling_on = !(n >= 250 && n < 400);
      if (n % 160 == 159) drain_results();
      if (idling_on && $urandom_range(99) < 35) idle_cycles($urandom_range(1, 4));
      if ($urandom_range(1)) begin
        send_item(OP_READ, $urandom, random_name(), INDEX_W'($urandom_range(7)));
      end else begin
        // a slowly rising base keeps insertions and ties coming
        drift += $urandom_range(2);
        pick = $urandom_range(99);
        if (pick < 80) sc = drift + $urandom_range(12) - 6;
        else if (pick < 95) sc = {1'b1, 31'($urandom)};
        else sc = drift;
        send_item(OP_SUBMIT, sc, random_name(), INDEX_W'($urandom_range(7)));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("ran %0d submits (%0d placed) and %0d reads", submits, placed, reads);
    $display("with ties, rejections, score extremes and names cut at zero bytes");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== top_k_score_table_insert.f =====
design/tkst_pkg.sv
design/tkst_cell.sv
design/top_k_score_table_insert.sv
tb/score_table_checker.sv
tb/tb_top.sv
